[rtl/ffra_pkg.sv]
// Package for the first-fit region allocator: sizes, codes, controller state
// and the command/status structs between controller and datapath.
// No dependencies.
package ffra_pkg;

    localparam int Entries   = 4096;
    localparam int AddrWidth = 32;
    localparam int IdxWidth  = $clog2(Entries);
    localparam int CntWidth  = 13;
    localparam int TotWidth  = 33;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_LOST   = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_WAIT,
        S_EVAL,
        S_SHIFT_RD,
        S_SHIFT_WAIT,
        S_SHIFT_WR,
        S_TOT_RD,
        S_TOT_WAIT,
        S_TOT_ACC,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;    // take a new item
        logic scan_rd;     // read entry at scan index
        logic eval;        // decide on the entry just read
        logic shift_rd;    // read the entry to move
        logic shift_wr;    // write the moved entry
        logic tot_rd;      // read entry for the total sweep
        logic tot_acc;     // add it into the total
        logic finish;      // drive the result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;    // eval: scan finished
        logic shift_go;    // eval: a shift pass is needed
        logic shift_end;   // no more entries to move
        logic tot_end;     // total sweep finished
    } sts_t;

endpackage

[rtl/ffra_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module ffra_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

[rtl/ffra_ctrl.sv]
// Controller state machine of the region allocator.
// Depends on ffra_pkg.
module ffra_ctrl import ffra_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output cmd_t cmd,
    input  sts_t sts
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (start) state_next = S_RD;
            S_RD:         state_next = S_WAIT;
            S_WAIT:       state_next = S_EVAL;
            S_EVAL:
            begin
                if (sts.shift_go)      state_next = S_SHIFT_RD;
                else if (sts.scan_end) state_next = S_TOT_RD;
                else                   state_next = S_RD;
            end
            S_SHIFT_RD:   state_next = sts.shift_end ? S_TOT_RD : S_SHIFT_WAIT;
            S_SHIFT_WAIT: state_next = S_SHIFT_WR;
            S_SHIFT_WR:   state_next = S_SHIFT_RD;
            S_TOT_RD:     state_next = sts.tot_end ? S_DONE : S_TOT_WAIT;
            S_TOT_WAIT:   state_next = S_TOT_ACC;
            S_TOT_ACC:    state_next = S_TOT_RD;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:       cmd.latch_in = start;
            S_RD:         cmd.scan_rd = 1'b1;
            S_EVAL:       cmd.eval = 1'b1;
            S_SHIFT_RD:   cmd.shift_rd = 1'b1;
            S_SHIFT_WAIT: cmd.shift_rd = 1'b1;   // keep the source address on the RAM
            S_SHIFT_WR:   cmd.shift_wr = 1'b1;
            S_TOT_RD:     cmd.tot_rd = 1'b1;
            S_TOT_ACC:    cmd.tot_acc = 1'b1;
            S_DONE:       cmd.finish = 1'b1;
            default:      cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE) else $error("done not followed by idle");
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && start |=> state_reg == S_RD) else $error("start not taken");
    a_wr_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT_WR |-> $past(state_reg) == S_SHIFT_WAIT) else $error("bad shift order");
`endif
endmodule

[rtl/ffra_dp.sv]
// Datapath of the region allocator: region tables, scan, shift and total sweep.
// Depends on ffra_pkg and ffra_ram.
module ffra_dp import ffra_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 action,
    input  logic [AddrWidth-1:0] addr,
    input  logic [AddrWidth-1:0] size,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 done,
    output logic [AddrWidth-1:0] alloc_addr,
    output logic [1:0]           status,
    output logic [TotWidth-1:0]  free_total,
    output logic [CntWidth-1:0]  region_count,
    output logic [CntWidth-1:0]  peak_count,
    output logic [31:0]          lost_count,
    output logic [31:0]          lost_bytes
);
    localparam logic [TotWidth-1:0] TotMax = '1;

    // Latched request
    logic                 act_reg;
    logic [AddrWidth-1:0] addr_reg, size_reg;
    // Scan position and the previous entry seen
    logic [CntWidth-1:0]  idx_reg, idx_next;
    logic [AddrWidth-1:0] pstart_reg, pstart_next, psize_reg, psize_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next, peak_reg, peak_next;
    logic [31:0]          lcnt_reg, lcnt_next, lbytes_reg, lbytes_next;
    logic [AddrWidth-1:0] got_reg, got_next;
    status_t              st_reg, st_next;
    // Shift pass: dir 1 moves entries up (insert), 0 moves down (remove)
    logic                 sdir_reg, sdir_next;
    logic [CntWidth-1:0]  spos_reg, spos_next, send_reg, send_next;
    logic [TotWidth-1:0]  tot_reg, tot_next;

    // RAM ports
    logic                 we;
    logic [IdxWidth-1:0]  ram_a;
    logic [AddrWidth-1:0] wstart, wsize, rstart, rsize;

    ffra_ram #(.Width(AddrWidth), .Depth(Entries)) u_start (
        .clk(clk), .we(we), .addr(ram_a), .wdata(wstart), .rdata(rstart));
    ffra_ram #(.Width(AddrWidth), .Depth(Entries)) u_size (
        .clk(clk), .we(we), .addr(ram_a), .wdata(wsize), .rdata(rsize));

    logic [AddrWidth-1:0] fend, pend;
    assign fend = addr_reg + size_reg;
    assign pend = pstart_reg + psize_reg;

    logic [CntWidth-1:0] tgt;   // source index of the current shift step
    assign tgt = sdir_reg ? spos_reg - 1'b1 : spos_reg + 1'b1;

    logic [TotWidth-1:0] tsum;
    assign tsum = tot_reg + TotWidth'(rsize);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            peak_reg <= '0;
            lcnt_reg <= '0;
            lbytes_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            peak_reg <= peak_next;
            lcnt_reg <= lcnt_next;
            lbytes_reg <= lbytes_next;
            done <= cmd.finish;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg <= action;
            addr_reg <= addr;
            size_reg <= size;
        end
        idx_reg <= idx_next;
        pstart_reg <= pstart_next;
        psize_reg <= psize_next;
        got_reg <= got_next;
        st_reg <= st_next;
        sdir_reg <= sdir_next;
        spos_reg <= spos_next;
        send_reg <= send_next;
        tot_reg <= tot_next;
    end

    // Sequencing of scan, decision, shift and sweep
    always_comb
    begin
        idx_next = idx_reg;
        pstart_next = pstart_reg;
        psize_next = psize_reg;
        cnt_next = cnt_reg;
        peak_next = peak_reg;
        lcnt_next = lcnt_reg;
        lbytes_next = lbytes_reg;
        got_next = got_reg;
        st_next = st_reg;
        sdir_next = sdir_reg;
        spos_next = spos_reg;
        send_next = send_reg;
        tot_next = tot_reg;
        sts = '0;
        we = 1'b0;
        ram_a = idx_reg[IdxWidth-1:0];
        wstart = rstart;
        wsize = rsize;

        if (cmd.latch_in)
        begin
            idx_next = '0;
            got_next = '0;
            st_next = ST_OK;
            tot_next = '0;
        end

        if (cmd.eval)
        begin
            // idx_reg is the entry just read, valid when idx_reg < cnt_reg
            if (!act_reg)
            begin
                if (idx_reg >= cnt_reg)
                begin
                    st_next = ST_NOFIT;
                    sts.scan_end = 1'b1;
                end
                else if (rsize >= size_reg)
                begin
                    got_next = rstart;
                    we = 1'b1;
                    wstart = rstart + size_reg;
                    wsize = rsize - size_reg;
                    sts.scan_end = 1'b1;
                    if (rsize == size_reg)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        sdir_next = 1'b0;
                        spos_next = idx_reg;
                        send_next = cnt_reg - 1'b1;
                        sts.shift_go = 1'b1;
                    end
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            else if (idx_reg < cnt_reg && !(rstart > addr_reg))
            begin
                pstart_next = rstart;
                psize_next = rsize;
                idx_next = idx_reg + 1'b1;
            end
            else
            begin
                // idx_reg is pos; entry valid only if idx_reg < cnt_reg
                sts.scan_end = 1'b1;
                if (idx_reg != '0 && pend == addr_reg)
                begin
                    we = 1'b1;
                    ram_a = IdxWidth'(idx_reg - 1'b1);
                    wstart = pstart_reg;
                    wsize = psize_reg + size_reg;
                    if (idx_reg < cnt_reg && fend == rstart)
                    begin
                        wsize = psize_reg + size_reg + rsize;
                        cnt_next = cnt_reg - 1'b1;
                        sdir_next = 1'b0;
                        spos_next = idx_reg;
                        send_next = cnt_reg - 1'b1;
                        sts.shift_go = 1'b1;
                    end
                end
                else if (idx_reg < cnt_reg && fend == rstart)
                begin
                    we = 1'b1;
                    wstart = addr_reg;
                    wsize = rsize + size_reg;
                end
                else if (cnt_reg < CntWidth'(Entries))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (peak_reg < cnt_reg + 1'b1)
                        peak_next = cnt_reg + 1'b1;
                    sdir_next = 1'b1;
                    spos_next = cnt_reg;
                    send_next = idx_reg;
                    sts.shift_go = 1'b1;
                end
                else
                begin
                    st_next = ST_LOST;
                    lcnt_next = lcnt_reg + 1'b1;
                    lbytes_next = lbytes_reg + 32'(size_reg);
                end
            end
        end

        // Shift pass: spos is the slot written; on insert the last step puts the new item
        if (cmd.shift_rd)
        begin
            if (spos_reg == send_reg)
            begin
                sts.shift_end = 1'b1;
                if (sdir_reg)
                begin
                    we = 1'b1;
                    ram_a = spos_reg[IdxWidth-1:0];
                    wstart = addr_reg;
                    wsize = size_reg;
                end
            end
            else
                ram_a = tgt[IdxWidth-1:0];
        end
        if (cmd.shift_wr)
        begin
            we = 1'b1;
            ram_a = spos_reg[IdxWidth-1:0];
            spos_next = tgt;
        end

        // Total sweep over the live entries, reusing idx as the counter
        if (sts.shift_end || (cmd.eval && sts.scan_end && !sts.shift_go))
            idx_next = '0;
        if (cmd.tot_rd)
        begin
            ram_a = idx_reg[IdxWidth-1:0];
            sts.tot_end = (idx_reg >= cnt_reg);
        end
        if (cmd.tot_acc)
        begin
            tot_next = (tsum < tot_reg || tsum[TotWidth-1:AddrWidth] > 1'b1) ? TotMax : tsum;
            if (tot_reg == TotMax)
                tot_next = TotMax;
            idx_next = idx_reg + 1'b1;
        end
    end

    assign alloc_addr   = got_reg;
    assign status       = st_reg;
    assign free_total   = tot_reg;
    assign region_count = cnt_reg;
    assign peak_count   = peak_reg;
    assign lost_count   = lcnt_reg;
    assign lost_bytes   = lbytes_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntWidth'(Entries)) else $error("count over capacity");
    a_peak_ge: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= cnt_reg) else $error("peak below count");
    a_lost_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        lcnt_reg != $past(lcnt_reg) |-> $past(cnt_reg) == CntWidth'(Entries))
        else $error("loss with room left");
`endif
endmodule

[rtl/first_fit_region_allocator.sv]
// Top level of the first-fit region allocator with coalescing.
// Depends on ffra_pkg, ffra_ctrl, ffra_dp.
//
//  channel  | handshake          | payload
//  request  | start / busy       | action, addr, size
//  result   | done (strobe)      | alloc_addr, status, free_total, region_count,
//           |                    | peak_count, lost_count, lost_bytes
//
// A request scans the sorted table one entry at a time through a single
// RAM port (read, wait, evaluate), then a shift pass, if one is needed, moves
// entries one at a time (read, wait, write), then a total sweep reads every
// live entry (read, wait, accumulate); the one table port sets the pace.
// Reset empties the table at once (no clearing pass). Results appear for one
// cycle on done and cannot be stalled; busy holds off requests.
module first_fit_region_allocator import ffra_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 action,
    input  logic [AddrWidth-1:0] addr,
    input  logic [AddrWidth-1:0] size,
    output logic                 done,
    output logic [AddrWidth-1:0] alloc_addr,
    output logic [1:0]           status,
    output logic [TotWidth-1:0]  free_total,
    output logic [CntWidth-1:0]  region_count,
    output logic [CntWidth-1:0]  peak_count,
    output logic [31:0]          lost_count,
    output logic [31:0]          lost_bytes
);
    cmd_t cmd;
    sts_t sts;

    ffra_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts));

    ffra_dp u_dp (
        .clk(clk), .rst_n(rst_n), .action(action), .addr(addr), .size(size),
        .cmd(cmd), .sts(sts), .done(done), .alloc_addr(alloc_addr), .status(status),
        .free_total(free_total), .region_count(region_count), .peak_count(peak_count),
        .lost_count(lost_count), .lost_bytes(lost_bytes));
endmodule
